// ----- rtl/core/tpi_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the trajectory playback interpolator.
// No dependencies.
package tpi_pkg;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_JOINT_COUNT = 1'b1;

  localparam int CFG_WIDTH   = 11;
  localparam int PC_WIDTH    = 11;
  localparam int JC_WIDTH    = 4;
  localparam int VAL_WIDTH   = 32;
  localparam int NUM_WIDTH   = 65;
  localparam int QUO_WIDTH   = 33;
  localparam int STEP_WIDTH  = 7;

  typedef enum logic [3:0] {
    S_IDLE, S_FRD, S_FCK, S_BRD, S_BCK, S_JRA, S_JRB, S_JWB,
    S_PREP, S_MUL, S_DIV, S_DWAIT, S_EMIT
  } state_t;

endpackage

// ----- rtl/core/tpi_store.sv -----
`timescale 1ns / 1ps
// Point table: time memory per point and position/velocity/acceleration memories
// per point and joint. Synchronous read with a registered output. Uses tpi_pkg.
module tpi_store #(
  parameter int AW  = 10,
  parameter int DAW = 13
) (
  input  logic                            clk,
  input  logic                            t_we,
  input  logic [AW-1:0]                   t_waddr,
  input  logic [tpi_pkg::VAL_WIDTH-1:0]   t_wdata,
  input  logic [AW-1:0]                   t_raddr,
  output logic [tpi_pkg::VAL_WIDTH-1:0]   t_rdata,
  input  logic                            d_we,
  input  logic [DAW-1:0]                  d_waddr,
  input  logic [3*tpi_pkg::VAL_WIDTH-1:0] d_wdata,
  input  logic [DAW-1:0]                  d_raddr,
  output logic [3*tpi_pkg::VAL_WIDTH-1:0] d_rdata
);

  logic [tpi_pkg::VAL_WIDTH-1:0] time_mem [2**AW];
  logic [tpi_pkg::VAL_WIDTH-1:0] pos_mem  [2**DAW];
  logic [tpi_pkg::VAL_WIDTH-1:0] vel_mem  [2**DAW];
  logic [tpi_pkg::VAL_WIDTH-1:0] acc_mem  [2**DAW];

  always_ff @(posedge clk) begin
    if (t_we) begin
      time_mem[t_waddr] <= t_wdata;
    end
    t_rdata <= time_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      pos_mem[d_waddr] <= d_wdata[tpi_pkg::VAL_WIDTH-1:0];
      vel_mem[d_waddr] <= d_wdata[2*tpi_pkg::VAL_WIDTH-1:tpi_pkg::VAL_WIDTH];
      acc_mem[d_waddr] <= d_wdata[3*tpi_pkg::VAL_WIDTH-1:2*tpi_pkg::VAL_WIDTH];
    end
    d_rdata <= {acc_mem[d_raddr], vel_mem[d_raddr], pos_mem[d_raddr]};
  end

endmodule

// ----- rtl/core/tpi_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for the blend fraction.
// Uses tpi_pkg.
module tpi_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [tpi_pkg::NUM_WIDTH-1:0]  num,
  input  logic [tpi_pkg::VAL_WIDTH-1:0]  den,
  output logic                           done,
  output logic [tpi_pkg::QUO_WIDTH-1:0]  quo
);

  logic [tpi_pkg::NUM_WIDTH-1:0]  acc;
  logic [tpi_pkg::VAL_WIDTH-1:0]  rem;
  logic [tpi_pkg::VAL_WIDTH-1:0]  dvs;
  logic [tpi_pkg::STEP_WIDTH-1:0] cnt;
  logic                           run;
  logic [tpi_pkg::VAL_WIDTH:0]    rem_sh;
  logic                           ge;

  assign rem_sh = {rem, acc[tpi_pkg::NUM_WIDTH-1]};
  assign ge     = rem_sh >= {1'b0, dvs};
  assign quo    = acc[tpi_pkg::QUO_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == tpi_pkg::STEP_WIDTH'(tpi_pkg::NUM_WIDTH - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= num;
      rem <= '0;
      dvs <= den;
    end else if (run) begin
      // shift in next numerator bit, subtract where it fits
      rem <= ge ? tpi_pkg::VAL_WIDTH'(rem_sh - {1'b0, dvs}) : rem_sh[tpi_pkg::VAL_WIDTH-1:0];
      acc <= {acc[tpi_pkg::NUM_WIDTH-2:0], ge};
    end
  end

endmodule

// ----- rtl/core/trajectory_playback_interpolator_unit.sv -----
`timescale 1ns / 1ps
// Trajectory playback interpolator, top level. Uses tpi_pkg, tpi_store, tpi_div.
//
// Usage: an item is taken when start is high and busy is low. A load item
// (req_type 0) writes one joint of one point into the point table in that
// same cycle and leaves busy low. A query item (req_type 1) raises busy while
// the segment index walks the time table, one point at a time through the
// single time memory read port, then gives joint_count results (clamped to
// 1..MAX_JOINTS), each shown for one cycle with result_valid. The receiver
// cannot hold results off. Per joint: the sequencer fetches both points from
// the data memories and shows the result; when blending, each of the three
// values adds a prepare step, a 32x32 multiply, a divider start and a wait on
// the 65-step bit-serial divider. Blending is skipped when the point is held
// or past the end. Configuration writes (cfg_we, cfg_index, cfg_data) are
// taken at once; the user must make them only while busy is low, and the
// block itself does not enforce this.
// Reset clears the segment index and sets point_count 2, joint_count 7; the
// table contents are undefined until loaded.
module trajectory_playback_interpolator_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_JOINTS = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 req_type,
  input  logic [9:0]                           point_index,
  input  logic [2:0]                           joint_index,
  input  logic [31:0]                          point_time,
  input  logic signed [31:0]                   point_position,
  input  logic signed [31:0]                   point_velocity,
  input  logic signed [31:0]                   point_acceleration,
  input  logic [31:0]                          query_time,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [tpi_pkg::CFG_WIDTH-1:0]        cfg_data,
  output logic                                 result_valid,
  output logic [2:0]                           joint_number,
  output logic signed [31:0]                   position_out,
  output logic signed [31:0]                   velocity_out,
  output logic signed [31:0]                   acceleration_out,
  output logic                                 finished,
  output logic                                 last_joint
);

  localparam int AW  = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);
  localparam int JW  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int JCW = $clog2(MAX_JOINTS + 1);
  localparam int DAW = $clog2(MAX_POINTS * MAX_JOINTS);
  localparam int VW  = tpi_pkg::VAL_WIDTH;

  tpi_pkg::state_t state, state_next;

  logic [tpi_pkg::PC_WIDTH-1:0] point_count;
  logic [tpi_pkg::JC_WIDTH-1:0] joint_count;
  logic [AW-1:0]   seg;
  logic [CW-1:0]   n_q, n_cl;
  logic [JCW-1:0]  jc_q, jc_cl;
  logic [JW-1:0]   j;
  logic [VW-1:0]   t_q, t0r, t1r;
  logic            done_f, hold_f;
  logic signed [VW-1:0] p0 [3];
  logic signed [VW-1:0] p1 [3];
  logic signed [VW-1:0] res [3];
  logic [1:0]      k;
  logic [VW-1:0]   mag;
  logic            neg;
  logic [2*VW-1:0] prod;

  logic            take, t_we, d_we, div_go, div_done, fwd_more, last_j;
  logic [AW-1:0]   t_raddr;
  logic [DAW-1:0]  d_raddr, d_waddr, addr_a, addr_b;
  logic [VW-1:0]   t_rdata, span;
  logic [3*VW-1:0] d_rdata;
  logic [tpi_pkg::QUO_WIDTH-1:0] quo;
  logic signed [VW+2:0] blend_sum;
  logic signed [VW-1:0] blend_sat;
  logic signed [VW:0]   diff;

  assign busy = (state != tpi_pkg::S_IDLE);
  assign take = start && !busy;
  assign t_we = take && (req_type == tpi_pkg::REQ_LOAD) &&
                (32'(point_index) < MAX_POINTS) && (32'(joint_index) < MAX_JOINTS);
  assign d_we = t_we;
  assign d_waddr = DAW'(32'(point_index) * MAX_JOINTS + 32'(joint_index));

  always_comb begin
    if (32'(point_count) > 32'(MAX_POINTS)) n_cl = CW'(MAX_POINTS);
    else if (point_count < 2) n_cl = CW'(2);
    else n_cl = CW'(point_count);
    if (joint_count == 0) jc_cl = JCW'(1);
    else if (32'(joint_count) > 32'(MAX_JOINTS)) jc_cl = JCW'(MAX_JOINTS);
    else jc_cl = JCW'(joint_count);
  end

  assign fwd_more  = (32'(seg) + 2) < 32'(n_q);
  assign last_j    = (JCW'(j) + 1'b1) == jc_q;
  assign addr_a    = DAW'(32'(seg) * MAX_JOINTS + 32'(j));
  assign addr_b    = DAW'((32'(seg) + 1) * MAX_JOINTS + 32'(j));
  assign span      = t1r - t0r;
  assign diff      = (VW+1)'(p1[k]) - (VW+1)'(p0[k]);
  assign blend_sum = (VW+3)'(p0[k]) + (neg ? -(VW+3)'(signed'({1'b0, quo}))
                                             : (VW+3)'(signed'({1'b0, quo})));
  always_comb begin
    if (blend_sum > (VW+3)'(32'sh7FFFFFFF)) blend_sat = 32'sh7FFFFFFF;
    else if (blend_sum < -(VW+3)'(33'sh080000000)) blend_sat = 32'sh80000000;
    else blend_sat = VW'(blend_sum);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpi_pkg::S_IDLE:
        if (take && req_type == tpi_pkg::REQ_QUERY) state_next = tpi_pkg::S_FRD;
      tpi_pkg::S_FRD: state_next = tpi_pkg::S_FCK;
      tpi_pkg::S_FCK:
        if (fwd_more && t_q >= t_rdata) state_next = tpi_pkg::S_FRD;
        else if (t_q > t_rdata) state_next = tpi_pkg::S_JRA;
        else state_next = tpi_pkg::S_BRD;
      tpi_pkg::S_BRD: state_next = tpi_pkg::S_BCK;
      tpi_pkg::S_BCK:
        if (seg != '0 && t_q < t_rdata) state_next = tpi_pkg::S_BRD;
        else state_next = tpi_pkg::S_JRA;
      tpi_pkg::S_JRA: state_next = tpi_pkg::S_JRB;
      tpi_pkg::S_JRB: state_next = tpi_pkg::S_JWB;
      tpi_pkg::S_JWB:
        state_next = (done_f || hold_f) ? tpi_pkg::S_EMIT : tpi_pkg::S_PREP;
      tpi_pkg::S_PREP: state_next = tpi_pkg::S_MUL;
      tpi_pkg::S_MUL: state_next = tpi_pkg::S_DIV;
      tpi_pkg::S_DIV: state_next = tpi_pkg::S_DWAIT;
      tpi_pkg::S_DWAIT:
        if (div_done) state_next = (k == 2'd2) ? tpi_pkg::S_EMIT : tpi_pkg::S_PREP;
      tpi_pkg::S_EMIT: state_next = last_j ? tpi_pkg::S_IDLE : tpi_pkg::S_JRA;
      default: state_next = tpi_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    t_raddr      = seg;
    d_raddr      = addr_a;
    div_go       = 1'b0;
    result_valid = 1'b0;
    unique case (state)
      tpi_pkg::S_FRD: t_raddr = AW'(32'(seg) + 1);
      tpi_pkg::S_JRB: d_raddr = addr_b;
      tpi_pkg::S_DIV: div_go = 1'b1;
      tpi_pkg::S_EMIT: result_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= tpi_pkg::S_IDLE;
      point_count <= tpi_pkg::PC_WIDTH'(2);
      joint_count <= tpi_pkg::JC_WIDTH'(7);
      seg         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we && cfg_index == tpi_pkg::REG_POINT_COUNT) point_count <= cfg_data;
      if (cfg_we && cfg_index == tpi_pkg::REG_JOINT_COUNT)
        joint_count <= cfg_data[tpi_pkg::JC_WIDTH-1:0];
      if (state == tpi_pkg::S_IDLE && take && req_type == tpi_pkg::REQ_QUERY &&
          32'(seg) > 32'(n_cl) - 2) begin
        seg <= AW'(32'(n_cl) - 2);
      end else if (state == tpi_pkg::S_FCK && fwd_more && t_q >= t_rdata) begin
        seg <= seg + 1'b1;
      end else if (state == tpi_pkg::S_BCK && seg != '0 && t_q < t_rdata) begin
        seg <= seg - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      tpi_pkg::S_IDLE: begin
        t_q    <= query_time;
        n_q    <= n_cl;
        jc_q   <= jc_cl;
        j      <= '0;
        done_f <= 1'b0;
        hold_f <= 1'b0;
      end
      tpi_pkg::S_FCK: begin
        t1r <= t_rdata;
        if (!(fwd_more && t_q >= t_rdata) && t_q > t_rdata) done_f <= 1'b1;
      end
      tpi_pkg::S_BCK: begin
        if (seg != '0 && t_q < t_rdata) begin
          t1r <= t_rdata;
        end else begin
          t0r    <= t_rdata;
          hold_f <= (t_q < t_rdata) || (t1r == t_rdata);
        end
      end
      tpi_pkg::S_JRB: begin
        for (int i = 0; i < 3; i++) p0[i] <= d_rdata[i*VW +: VW];
      end
      tpi_pkg::S_JWB: begin
        for (int i = 0; i < 3; i++) p1[i] <= d_rdata[i*VW +: VW];
        k <= 2'd0;
        if (done_f) begin
          res[0] <= d_rdata[VW-1:0];
          res[1] <= '0;
          res[2] <= '0;
        end else begin
          for (int i = 0; i < 3; i++) res[i] <= p0[i];
        end
      end
      tpi_pkg::S_PREP: begin
        neg <= diff[VW];
        mag <= diff[VW] ? VW'(-diff) : diff[VW-1:0];
      end
      tpi_pkg::S_MUL: prod <= mag * (t_q - t0r);
      tpi_pkg::S_DWAIT: begin
        if (div_done) begin
          res[k] <= blend_sat;
          k      <= k + 1'b1;
        end
      end
      tpi_pkg::S_EMIT: j <= j + 1'b1;
      default: ;
    endcase
  end

  assign joint_number     = 3'(j);
  assign position_out     = res[0];
  assign velocity_out     = res[1];
  assign acceleration_out = res[2];
  assign finished         = done_f;
  assign last_joint       = last_j;

  tpi_store #(.AW(AW), .DAW(DAW)) u_store (
    .clk     (clk),
    .t_we    (t_we),
    .t_waddr (AW'(point_index)),
    .t_wdata (point_time),
    .t_raddr (t_raddr),
    .t_rdata (t_rdata),
    .d_we    (d_we),
    .d_waddr (d_waddr),
    .d_wdata ({point_acceleration, point_velocity, point_position}),
    .d_raddr (d_raddr),
    .d_rdata (d_rdata)
  );

  tpi_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (tpi_pkg::NUM_WIDTH'(prod) + tpi_pkg::NUM_WIDTH'(span >> 1)),
    .den  (span),
    .done (div_done),
    .quo  (quo)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for trajectory_playback_interpolator_unit.
// Depends on tpi_pkg and the block's RTL; predicts every joint result internally.
module testbench;

  typedef struct packed {
    logic [2:0]         joint;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               fin;
    logic               last;
  } joint_result_t;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0, busy;
  logic req_type = tpi_pkg::REQ_LOAD;
  logic [9:0] point_index = '0;
  logic [2:0] joint_index = '0;
  logic [31:0] point_time = '0, query_time = '0;
  logic signed [31:0] point_position = '0, point_velocity = '0, point_acceleration = '0;
  logic cfg_we = 1'b0, cfg_index = tpi_pkg::REG_POINT_COUNT;
  logic [tpi_pkg::CFG_WIDTH-1:0] cfg_data = '0;
  logic result_valid, finished, last_joint;
  logic [2:0] joint_number;
  logic signed [31:0] position_out, velocity_out, acceleration_out;

  trajectory_playback_interpolator_unit uut (.*);

  // Predictor state
  logic [31:0]        time_tab [1024];
  logic signed [31:0] pos_tab [8192];
  logic signed [31:0] vel_tab [8192];
  logic signed [31:0] acc_tab [8192];
  int unsigned        seg_now = 0;
  logic [tpi_pkg::PC_WIDTH-1:0] points_reg = 11'd2;
  logic [tpi_pkg::JC_WIDTH-1:0] joints_reg = 4'd7;

  joint_result_t pending_results[$];
  int mismatches = 0, checked = 0, queries = 0, loads = 0;
  longint cycles = 0;
  bit idling_on = 1'b1;
  logic [31:0] phase_times [1024];

  initial forever #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 64'd4000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [31:0] blend_value(logic signed [31:0] a, logic signed [31:0] b,
                                              logic [31:0] dt, logic [31:0] span);
    longint diff, res;
    logic [65:0] mag, q;
    bit neg;
    diff = longint'(b) - longint'(a);
    neg = diff < 0;
    mag = neg ? 66'(-diff) : 66'(diff);
    q = (mag * 66'(dt) + 66'(span >> 1)) / 66'(span);
    res = longint'(a) + (neg ? -longint'(q[63:0]) : longint'(q[63:0]));
    return res[31:0];
  endfunction

  task automatic predict_query(logic [31:0] t);
    int unsigned n, jc, seg, a, b;
    bit done, hold;
    joint_result_t r;
    done = 0;
    hold = 0;
    n = points_reg < 2 ? 2 : (points_reg > 1024 ? 1024 : points_reg);
    jc = joints_reg < 1 ? 1 : (joints_reg > 8 ? 8 : joints_reg);
    seg = seg_now;
    if (seg > n - 2) seg = n - 2;
    while (seg + 2 < n && t >= time_tab[seg + 1]) seg++;
    if (t > time_tab[seg + 1]) done = 1;
    else begin
      while (seg > 0 && t < time_tab[seg]) seg--;
      if (t < time_tab[seg]) hold = 1;
    end
    seg_now = seg;
    if (!done && !hold && time_tab[seg] == time_tab[seg + 1]) hold = 1;
    for (int j = 0; j < jc; j++) begin
      a = seg * 8 + j;
      b = (seg + 1) * 8 + j;
      r.joint = j[2:0];
      if (done) begin
        r.pos = pos_tab[(n - 1) * 8 + j];
        r.vel = '0;
        r.acc = '0;
      end else if (hold) begin
        r.pos = pos_tab[a];
        r.vel = vel_tab[a];
        r.acc = acc_tab[a];
      end else begin
        r.pos = blend_value(pos_tab[a], pos_tab[b], t - time_tab[seg], time_tab[seg + 1] - time_tab[seg]);
        r.vel = blend_value(vel_tab[a], vel_tab[b], t - time_tab[seg], time_tab[seg + 1] - time_tab[seg]);
        r.acc = blend_value(acc_tab[a], acc_tab[b], t - time_tab[seg], time_tab[seg + 1] - time_tab[seg]);
      end
      r.fin = done;
      r.last = (j == jc - 1);
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  always @(posedge clk) begin
    joint_result_t got, want;
    if (!rst && result_valid) begin
      got = '{joint_number, position_out, velocity_out, acceleration_out, finished, last_joint};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = pending_results.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // One transfer; the item is taken at the first edge with busy low.
  task automatic send_item(logic kind, logic [9:0] pi, logic [2:0] ji, logic [31:0] pt,
                           logic [31:0] pp, logic [31:0] pv, logic [31:0] pa, logic [31:0] qt);
    @(negedge clk);
    start = 1'b1;
    req_type = kind;
    point_index = pi;
    joint_index = ji;
    point_time = pt;
    point_position = pp;
    point_velocity = pv;
    point_acceleration = pa;
    query_time = qt;
    do @(posedge clk); while (busy);
    if (kind == tpi_pkg::REQ_QUERY) begin
      queries++;
      predict_query(qt);
    end else begin
      loads++;
      time_tab[pi] = pt;
      pos_tab[pi * 8 + ji] = pp;
      vel_tab[pi * 8 + ji] = pv;
      acc_tab[pi * 8 + ji] = pa;
    end
  endtask

  task automatic sender_gap();
    int len;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      len = $urandom_range(1, 19);
      @(negedge clk);
      start = 1'b0;
      repeat (len - 1) @(negedge clk);
    end
  endtask

  task automatic load_point(int p, int j, logic [31:0] t);
    logic [31:0] v [3];
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 5))
        0: v[k] = 32'h7FFFFFFF;
        1: v[k] = 32'h80000000;
        2: v[k] = $urandom_range(0, 65535) - 32768;
        default: v[k] = $urandom;
      endcase
    send_item(tpi_pkg::REQ_LOAD, p[9:0], j[2:0], t, v[0], v[1], v[2], $urandom);
    sender_gap();
  endtask

  task automatic query(logic [31:0] t);
    send_item(tpi_pkg::REQ_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, t);
    sender_gap();
  endtask

  // Hold the sender until every outstanding result has come and the block is idle.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [tpi_pkg::CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == tpi_pkg::REG_POINT_COUNT) points_reg = val;
    else joints_reg = val[tpi_pkg::JC_WIDTH-1:0];
  endtask

  // Build a table of n points: sorted fine or sorted coarse, both with duplicates, or unsorted.
  task automatic fill_table(int n, int joints, int mode);
    logic [32:0] t;
    t = (mode == 1) ? $urandom_range(0, 1000) : $urandom;
    for (int p = 0; p < n; p++) begin
      if (mode == 2) phase_times[p] = $urandom;
      else begin
        phase_times[p] = t[32] ? 32'hFFFFFFFF : t[31:0];
        if ($urandom_range(0, 7) != 0)
          t = t + (mode == 1 ? 33'($urandom_range(1, 1 << 26)) : 33'($urandom_range(1, 200)));
      end
      for (int j = 0; j < joints; j++) load_point(p, j, phase_times[p]);
    end
  endtask

  function automatic logic [31:0] pick_time(int n);
    logic [31:0] lo, hi;
    lo = phase_times[0];
    hi = phase_times[n - 1];
    case ($urandom_range(0, 9))
      0: return lo - $urandom_range(0, 100);
      1: return hi + $urandom_range(0, 100);
      2: return phase_times[$urandom_range(0, n - 1)];
      3: return $urandom;
      4: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFFFFFF;
      default: return (lo <= hi) ? lo + 32'(64'($urandom) % (64'(hi) - 64'(lo) + 1)) : $urandom;
    endcase
  endfunction

  task automatic test_directed();
    write_reg(tpi_pkg::REG_POINT_COUNT, 11'd0);
    write_reg(tpi_pkg::REG_JOINT_COUNT, 11'd15);
    for (int j = 0; j < 8; j++) begin
      send_item(tpi_pkg::REQ_LOAD, 10'd0, j[2:0], 32'd100, 32'h80000000, 32'h7FFFFFFF, j, 0);
      send_item(tpi_pkg::REQ_LOAD, 10'd1, j[2:0], 32'd1000, 32'h7FFFFFFF, 32'h80000000, -j, 0);
    end
    query(32'd0);
    query(32'd100);
    query(32'd550);
    query(32'd1000);
    query(32'd1001);
    query(32'hFFFFFFFF);
    drain();
    // zero-length segment
    send_item(tpi_pkg::REQ_LOAD, 10'd1, 3'd7, 32'd100, 32'd5, 32'd6, 32'd7, 0);
    query(32'd100);
    query(32'd50);
    query(32'd200);
    drain();
    // point count above the table size; keep queries on the two loaded points
    write_reg(tpi_pkg::REG_POINT_COUNT, 11'd2047);
    query(32'd50);
    query(32'd0);
    drain();
  endtask

  task automatic test_long_table();
    write_reg(tpi_pkg::REG_POINT_COUNT, 11'd96);
    write_reg(tpi_pkg::REG_JOINT_COUNT, 11'd0);
    fill_table(96, 1, 1);
    for (int k = 0; k < 6; k++) query(pick_time(96));
    query(phase_times[95]);
    query(phase_times[0]);
    drain();
  endtask

  task automatic test_random_phases();
    int n, jc, jce;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 7) idling_on = 1'b0;
      n = (ph == 4) ? 16 : $urandom_range(2, 5);
      jc = (ph == 4) ? $urandom_range(0, 2) : $urandom_range(0, 15);
      jce = (jc == 0) ? 1 : ((jc > 8) ? 8 : jc);
      write_reg(tpi_pkg::REG_POINT_COUNT, 11'(n));
      write_reg(tpi_pkg::REG_JOINT_COUNT, 11'(jc));
      fill_table(n, jce, $urandom_range(0, 2));
      for (int k = 0; k < 8; k++) query(pick_time(n));
      drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_long_table();
    test_random_phases();
    drain();
    repeat (50) @(negedge clk);
    $display("covered %0d loads and %0d queries over several table sizes and joint counts",
             loads, queries);
    $display("%0d joint results checked, %0d mismatches", checked, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
